@@ sv/trt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trt_pkg
// Shared types and codes of the tree route table engine.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int NODE_W = 8;
  localparam int SELF_W = 5;

  typedef logic [NODE_W-1:0] node_t;

  localparam node_t NO_PARENT = 8'hFF;
  localparam node_t ROOT_NODE = 8'h01;
  localparam node_t NULL_NODE = 8'h00;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_ALLOC  = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic REG_SELF   = 1'b0;
  localparam logic REG_UPLINK = 1'b1;

  // one access to the parent table per cycle
  typedef struct packed {
    logic  rd;
    logic  wr;
    node_t addr;
    node_t wdata;
  } tbl_req_t;

endpackage

@@ sv/tree_route_table_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_route_table_engine_unit
// Parent-pointer routing table of a tree mesh: update, next hop, allocate,
// ancestor query.
// ----------------------------------------------------------------------------
// One word at a time: a request is taken only while the engine is idle, and
// the response register lets the next request in while a response waits.
// All parent reads go through the single port of the table memory, each
// parent step being a read from the walk state and a capture in the wait
// state, so the time per word is set by the walks of next hop, ancestor
// query and update and by the allocate scan; an update that removes a parent
// (peer 255) then re-walks every entry. Every word then ends with a sweep
// that counts the children of self_address, loads the response register
// and returns to idle to take the next request. The table is usable right
// after reset; there is no clearing pass.
// ----------------------------------------------------------------------------
module tree_route_table_engine_unit #(
  parameter int NODES = 32
) (
  input  logic           clk,
  input  logic           rst,
  // configuration
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data,
  // request channel
  input  logic           req_valid,
  output logic           req_stall,
  input  logic [1:0]     cmd,
  input  trt_pkg::node_t node_id,
  input  trt_pkg::node_t peer_node,
  // response channel
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output trt_pkg::node_t answer,
  output logic           granted,
  output logic [5:0]     child_count,
  output logic           walk_overflow
);
  import trt_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int SW = $clog2(NODES + 1);
  localparam int CW = (SW < 7) ? 7 : SW;
  localparam logic [AW-1:0] LAST_IDX = AW'(NODES - 1);
  localparam logic [SW-1:0] STEP_MAX = SW'(NODES);
  localparam node_t NODES_N = node_t'(NODES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_HOP0   = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_WAIT   = 4'd4;
  localparam logic [3:0] S_MARK   = 4'd5;
  localparam logic [3:0] S_PRUNE  = 4'd6;
  localparam logic [3:0] S_ALLOC  = 4'd7;
  localparam logic [3:0] S_COUNT0 = 4'd8;
  localparam logic [3:0] S_CNT_RD = 4'd9;
  localparam logic [3:0] S_CNT_WT = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]        state;
  logic [SELF_W-1:0] self_addr;
  node_t             uplink;
  logic [NODES-1:0]  free_map;
  logic              pruning;

  logic [1:0]        cmd_q;
  node_t             node_q;
  node_t             peer_q;
  node_t             n;
  node_t             t;
  node_t             prev;
  logic [SW-1:0]     steps;
  logic [AW-1:0]     idx;
  node_t             ans_acc;
  logic              grant_acc;
  logic              cut_acc;
  logic [CW-1:0]     cnt_acc;

  tbl_req_t          tbl_req;
  node_t             rd_data;

  node_t             self_ext;
  node_t             idx_node;
  node_t             miss_hop;
  logic              term;
  logic              at_limit;
  logic              walk_end;
  logic              found;
  logic              reached;
  logic [NODES-1:0]  mark_bits;

  trt_table #(.NODES(NODES)) u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  assign self_ext = {{(NODE_W-SELF_W){1'b0}}, self_addr};
  assign idx_node = {{(NODE_W-AW){1'b0}}, idx};
  assign miss_hop = (self_ext == ROOT_NODE) ? NO_PARENT : uplink;

  // walk stops at no parent, at the root, at the node it is looking for, or at the step limit
  assign term     = (n == NO_PARENT) || (n == ROOT_NODE) || (n == t);
  assign at_limit = (steps == STEP_MAX);
  assign walk_end = term || at_limit;
  assign found    = term && (n == t);
  assign reached  = term && (n != NO_PARENT);

  assign req_stall = (state != S_IDLE);

  // addresses an update takes out of the free map
  always_comb begin
    mark_bits = '0;
    if (node_q < NODES_N) begin
      mark_bits[node_q[AW-1:0]] = 1'b1;
    end
    if (peer_q < NODES_N) begin
      mark_bits[peer_q[AW-1:0]] = 1'b1;
    end
  end

  // reads and writes never fall in the same cycle, so no forwarding is needed
  always_comb begin
    tbl_req = '0;
    case (state)
      S_START: begin
        if (cmd_q == CMD_LOOKUP && node_q != ROOT_NODE && node_q < NODES_N) begin
          tbl_req.rd   = 1'b1;
          tbl_req.addr = node_q;
        end
      end
      S_WALK: begin
        if (walk_end) begin
          if (cmd_q == CMD_UPDATE) begin
            if (pruning && !reached) begin
              tbl_req.wr    = 1'b1;
              tbl_req.addr  = idx_node;
              tbl_req.wdata = NO_PARENT;
            end else if (!pruning && !found) begin
              tbl_req.wr    = 1'b1;
              tbl_req.addr  = node_q;
              tbl_req.wdata = peer_q;
            end
          end
        end else if (n < NODES_N) begin
          tbl_req.rd   = 1'b1;
          tbl_req.addr = n;
        end
      end
      S_CNT_RD: begin
        tbl_req.rd   = 1'b1;
        tbl_req.addr = idx_node;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      self_addr <= '0;
      uplink    <= '0;
      free_map  <= '1;
      pruning   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SELF:   self_addr <= cfg_data[SELF_W-1:0];
          REG_UPLINK: uplink    <= cfg_data;
          default: ;
        endcase
      end

      // the done state reloads the response register itself
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q     <= cmd;
            node_q    <= node_id;
            peer_q    <= peer_node;
            ans_acc   <= NULL_NODE;
            grant_acc <= 1'b0;
            cut_acc   <= 1'b0;
            pruning   <= 1'b0;
            state     <= S_START;
          end
        end

        S_START: begin
          steps <= '0;
          case (cmd_q)
            CMD_UPDATE: begin
              if (node_q < NODES_N && (peer_q < NODES_N || peer_q == NO_PARENT) &&
                  peer_q != NULL_NODE) begin
                // refuse the write if node is already above the new parent
                n     <= peer_q;
                t     <= node_q;
                state <= S_WALK;
              end else begin
                state <= S_MARK;
              end
            end
            CMD_LOOKUP: begin
              if (node_q == ROOT_NODE) begin
                ans_acc <= uplink;
                state   <= S_COUNT0;
              end else if (node_q < NODES_N) begin
                state <= S_HOP0;
              end else begin
                n     <= NO_PARENT;
                prev  <= node_q;
                t     <= self_ext;
                state <= S_WALK;
              end
            end
            CMD_ALLOC: begin
              idx   <= AW'(2);
              state <= S_ALLOC;
            end
            default: begin
              n     <= peer_q;
              t     <= node_q;
              state <= S_WALK;
            end
          endcase
        end

        S_HOP0: begin
          if (rd_data == NULL_NODE) begin
            ans_acc <= NO_PARENT;
            state   <= S_COUNT0;
          end else begin
            n     <= rd_data;
            prev  <= node_q;
            t     <= self_ext;
            state <= S_WALK;
          end
        end

        S_WALK: begin
          if (walk_end) begin
            if (!term) begin
              cut_acc <= 1'b1;
            end
            case (cmd_q)
              CMD_UPDATE: begin
                if (pruning) begin
                  if (idx == LAST_IDX) begin
                    state <= S_COUNT0;
                  end else begin
                    idx   <= idx + AW'(1);
                    state <= S_PRUNE;
                  end
                end else begin
                  grant_acc <= !found;
                  state     <= S_MARK;
                end
              end
              CMD_LOOKUP: begin
                if (!term) begin
                  ans_acc <= NO_PARENT;
                end else if (n == NO_PARENT) begin
                  ans_acc <= miss_hop;
                end else begin
                  ans_acc <= prev;
                end
                state <= S_COUNT0;
              end
              CMD_QUERY: begin
                grant_acc <= found;
                state     <= S_COUNT0;
              end
              default: state <= S_COUNT0;
            endcase
          end else begin
            prev <= n;
            if (n < NODES_N) begin
              state <= S_WAIT;
            end else begin
              // parent of an address past the table
              n     <= NO_PARENT;
              steps <= steps + SW'(1);
            end
          end
        end

        S_WAIT: begin
          n     <= rd_data;
          steps <= steps + SW'(1);
          state <= S_WALK;
        end

        S_MARK: begin
          free_map <= free_map & ~mark_bits;
          if (peer_q == NO_PARENT) begin
            pruning <= 1'b1;
            idx     <= '0;
            state   <= S_PRUNE;
          end else begin
            state <= S_COUNT0;
          end
        end

        S_PRUNE: begin
          n     <= idx_node;
          t     <= self_ext;
          steps <= '0;
          state <= S_WALK;
        end

        S_ALLOC: begin
          if (free_map[idx]) begin
            free_map[idx] <= 1'b0;
            ans_acc       <= idx_node;
            grant_acc     <= 1'b1;
            state         <= S_COUNT0;
          end else if (idx == LAST_IDX) begin
            state <= S_COUNT0;
          end else begin
            idx <= idx + AW'(1);
          end
        end

        S_COUNT0: begin
          idx     <= '0;
          cnt_acc <= '0;
          state   <= S_CNT_RD;
        end

        S_CNT_RD: begin
          state <= S_CNT_WT;
        end

        S_CNT_WT: begin
          if (rd_data == self_ext) begin
            cnt_acc <= cnt_acc + CW'(1);
          end
          if (idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_CNT_RD;
          end
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid     <= 1'b1;
            answer        <= ans_acc;
            granted       <= grant_acc;
            walk_overflow <= cut_acc;
            child_count   <= (cnt_acc > CW'(63)) ? 6'd63 : cnt_acc[5:0];
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/trt_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trt_table
// Parent table memory, one access per cycle, registered read. Entries never
// written since reset read as no parent.
// ----------------------------------------------------------------------------
module trt_table #(
  parameter int NODES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  trt_pkg::tbl_req_t req,
  output trt_pkg::node_t   rd_data
);
  import trt_pkg::*;

  localparam int AW = $clog2(NODES);

  node_t            mem [NODES];
  logic [NODES-1:0] written;
  node_t            mem_q;
  logic             hit_q;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.rd) begin
      mem_q <= mem[req.addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (req.wr) begin
        written[req.addr[AW-1:0]] <= 1'b1;
      end
      if (req.rd) begin
        hit_q <= written[req.addr[AW-1:0]];
      end
    end
  end

  assign rd_data = hit_q ? mem_q : NO_PARENT;

endmodule

@@ sv/trt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trt_checker
// Port-level checks of the tree route table engine, bound to the top level.
// ----------------------------------------------------------------------------
module trt_checker #(
  parameter int NODES = 32
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic [1:0]     cmd,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input trt_pkg::node_t answer,
  input logic           granted,
  input logic [5:0]     child_count,
  input logic           walk_overflow
);
  import trt_pkg::*;

  localparam int CAP = (NODES < 63) ? NODES : 63;

  logic       push;
  logic       pop;
  logic [1:0] q0;
  logic [1:0] q1;
  logic [1:0] depth;

  assign push = req_valid && !req_stall;
  assign pop  = rsp_valid && !rsp_stall;

  // commands of the words between request and response, oldest first
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (depth == 2'd0) begin
            q0 <= cmd;
          end else begin
            q1 <= cmd;
          end
          depth <= depth + 2'd1;
        end
        2'b01: begin
          q0    <= q1;
          depth <= depth - 2'd1;
        end
        2'b11: begin
          if (depth == 2'd1) begin
            q0 <= cmd;
          end else begin
            q0 <= q1;
            q1 <= cmd;
          end
        end
        default: ;
      endcase
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(answer) && $stable(granted) &&
      $stable(child_count) && $stable(walk_overflow))
    else $error("response word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    push |=> req_stall)
    else $error("request taken while a word is still in work");

  a_alloc_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && depth != 2'd0 && q0 == CMD_ALLOC |-> granted == (answer != NULL_NODE))
    else $error("allocate grant does not match the address");

  a_no_answer: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && depth != 2'd0 && (q0 == CMD_UPDATE || q0 == CMD_QUERY) |->
      answer == NULL_NODE)
    else $error("update or query returned an address");

  a_child_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> child_count <= 6'(CAP))
    else $error("child count above table size");

endmodule

bind tree_route_table_engine_unit trt_checker #(.NODES(NODES)) u_trt_checker (.*);

@@ tb/tree_route_table_engine_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_route_table_engine_unit_tb
// Self-checking bench for the tree route table engine. A local copy of the
// parent table, the free map and both registers predicts every response word,
// which is checked field by field while both ports idle and stall at random.
// ----------------------------------------------------------------------------
module tree_route_table_engine_unit_tb;
  import trt_pkg::*;

  localparam int NODES      = 32;
  localparam int QUIET_MAX  = 20000;
  localparam int SETTLE     = 300;
  localparam int RAND_WORDS = 280;
  localparam int SEGMENTS   = 6;

  typedef struct packed {
    logic [1:0] op;
    node_t      node;
    node_t      peer;
  } route_req_t;

  typedef struct packed {
    node_t      answer;
    logic       granted;
    logic [5:0] child_count;
    logic       walk_overflow;
  } route_rsp_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = REG_SELF;
  logic [7:0] cfg_data  = '0;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [1:0] cmd       = CMD_UPDATE;
  node_t      node_id   = NULL_NODE;
  node_t      peer_node = NULL_NODE;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  node_t      answer;
  logic       granted;
  logic [5:0] child_count;
  logic       walk_overflow;

  // local copy of the engine state
  node_t      route_tbl [NODES];
  logic       addr_free [NODES];
  logic [4:0] self_addr   = '0;
  node_t      uplink_addr = NULL_NODE;
  logic       walk_cut;

  route_req_t pending_reqs[$];
  route_rsp_t results_due[$];
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         bad_words   = 0;
  int         quiet       = 0;

  tree_route_table_engine_unit #(.NODES(NODES)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .node_id      (node_id),
    .peer_node    (peer_node),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .answer       (answer),
    .granted      (granted),
    .child_count  (child_count),
    .walk_overflow(walk_overflow)
  );

  always #2 clk = ~clk;

  function automatic node_t self_node();
    return {3'b000, self_addr};
  endfunction

  function automatic node_t parent_at(node_t a);
    return (a < NODES) ? route_tbl[a] : NO_PARENT;
  endfunction

  // chain ends at the root or at this node
  function automatic logic reaches_anchor(node_t n);
    int steps;
    steps = 0;
    while (!(n == NO_PARENT || n == ROOT_NODE || n == self_node())) begin
      if (steps >= NODES) begin
        walk_cut = 1'b1;
        return 1'b0;
      end
      n = parent_at(n);
      steps++;
    end
    return n != NO_PARENT;
  endfunction

  function automatic logic ancestor_holds(node_t a, node_t b);
    node_t n;
    int    steps;
    n = b;
    steps = 0;
    while (!(n == NO_PARENT || n == ROOT_NODE || n == a)) begin
      if (steps >= NODES) begin
        walk_cut = 1'b1;
        return 1'b0;
      end
      n = parent_at(n);
      steps++;
    end
    return n == a;
  endfunction

  function automatic node_t hop_toward(node_t target);
    node_t prev, up;
    int    steps;
    if (target == ROOT_NODE) return uplink_addr;
    prev = target;
    steps = 0;
    up = parent_at(target);
    if (up == NULL_NODE) return NO_PARENT;
    while (up != NO_PARENT) begin
      if (up == self_node() || up == ROOT_NODE) return prev;
      if (steps >= NODES) begin
        walk_cut = 1'b1;
        return NO_PARENT;
      end
      prev = up;
      up = parent_at(up);
      steps++;
    end
    return (self_node() == ROOT_NODE) ? NO_PARENT : uplink_addr;
  endfunction

  function automatic route_rsp_t predict_route(logic [1:0] op, node_t node, node_t peer);
    route_rsp_t r;
    int         i, kids;
    r = '0;
    walk_cut = 1'b0;
    kids = 0;
    case (op)
      CMD_UPDATE: begin
        // the loop check only runs once the address checks pass
        if (node < NODES && (peer < NODES || peer == NO_PARENT) && peer != NULL_NODE) begin
          if (!ancestor_holds(node, peer)) begin
            route_tbl[node] = peer;
            r.granted = 1'b1;
          end
        end
        if (node < NODES) addr_free[node] = 1'b0;
        if (peer < NODES) addr_free[peer] = 1'b0;
        if (peer == NO_PARENT) begin
          for (i = 0; i < NODES; i++) begin
            if (!reaches_anchor(node_t'(i))) route_tbl[i] = NO_PARENT;
          end
        end
      end
      CMD_LOOKUP: r.answer = hop_toward(node);
      CMD_ALLOC: begin
        for (i = 2; i < NODES; i++) begin
          if (addr_free[i] && !r.granted) begin
            addr_free[i] = 1'b0;
            r.answer = node_t'(i);
            r.granted = 1'b1;
          end
        end
      end
      CMD_QUERY: r.granted = ancestor_holds(node, peer);
    endcase
    for (i = 0; i < NODES; i++) begin
      if (route_tbl[i] == self_node()) kids++;
    end
    r.child_count = (kids > 63) ? 6'd63 : kids[5:0];
    r.walk_overflow = walk_cut;
    return r;
  endfunction

  function automatic node_t pick_child();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return NULL_NODE;
    if (r == 1) return ROOT_NODE;
    return node_t'($urandom_range(2, NODES - 1));
  endfunction

  function automatic node_t pick_parent();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return ROOT_NODE;
    if (r == 3) return self_node();
    if (r == 4) return NULL_NODE;
    return node_t'($urandom_range(2, NODES - 1));
  endfunction

  // mostly tree building and walks inside the table, some raw noise
  function automatic route_req_t random_request();
    route_req_t r;
    int         pick;
    pick = $urandom_range(0, 99);
    r.op   = CMD_UPDATE;
    r.node = node_t'($urandom_range(0, 255));
    r.peer = node_t'($urandom_range(0, 255));
    if (pick < 30) begin
      r.node = pick_child();
      r.peer = pick_parent();
    end else if (pick < 37) begin
      r.node = node_t'($urandom_range(0, NODES - 1));
      r.peer = NO_PARENT;
    end else if (pick < 57) begin
      r.op = CMD_LOOKUP;
      if ($urandom_range(0, 9) != 0) r.node = node_t'($urandom_range(0, NODES - 1));
    end else if (pick < 67) begin
      r.op = CMD_ALLOC;
    end else if (pick < 87) begin
      r.op   = CMD_QUERY;
      r.node = pick_parent();
      r.peer = ($urandom_range(0, 9) == 0) ? NO_PARENT : pick_child();
    end else begin
      r.op = 2'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic push_req(input logic [1:0] op, input node_t node, input node_t peer);
    pending_reqs.push_back('{op, node, peer});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] self_v, input node_t uplink_v);
    logic [2:0] junk;
    junk = 3'($urandom_range(0, 7));
    // upper bits of the self register write are ignored
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SELF;
    cfg_data  <= {junk, self_v};
    self_addr = self_v;
    @(posedge clk);
    cfg_index <= REG_UPLINK;
    cfg_data  <= uplink_v;
    uplink_addr = uplink_v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // request driver: payload holds while stalled
  always @(posedge clk) begin : drive_req
    route_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall)
        results_due.push_back(predict_route(cmd, node_id, peer_node));
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = pending_reqs.pop_front();
          req_valid <= 1'b1;
          cmd       <= nxt.op;
          node_id   <= nxt.node;
          peer_node <= nxt.peer;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin : check_rsp
    route_rsp_t want, got;
    rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    if (!rst && rsp_valid && !rsp_stall) begin
      got = {answer, granted, child_count, walk_overflow};
      if (results_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: answer=%0d granted=%0d children=%0d cut=%0d",
                   got.answer, got.granted, got.child_count, got.walk_overflow);
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          bad_words++;
          if (bad_words <= 10)
            $display("mismatch: want answer=%0d granted=%0d children=%0d cut=%0d, %s%0d %0d %0d %0d",
                     want.answer, want.granted, want.child_count, want.walk_overflow,
                     "got ", got.answer, got.granted, got.child_count, got.walk_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : sequencer
    int seg, i;
    for (i = 0; i < NODES; i++) begin
      route_tbl[i] = NO_PARENT;
      addr_free[i] = 1'b1;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      // sender pauses here until every word is back
      wait_drained();
      repeat (8) @(posedge clk);
      case (seg)
        0: set_config(5'd1, 8'hA5);
        1: set_config(5'd31, NO_PARENT);
        2: set_config(5'd0, NULL_NODE);
        3: set_config(5'($urandom_range(2, 30)), node_t'($urandom_range(0, 255)));
        4: set_config(5'd5, ROOT_NODE);
        default: set_config(5'd1, NO_PARENT);
      endcase
      tx_idle_pct = (seg < 2) ? 10 : (seg < 4) ? 52 : 0;
      rx_idle_pct = (seg < 2) ? 52 : (seg < 4) ? 10 : 0;
      if (seg == 0) begin
        push_req(CMD_ALLOC,  NULL_NODE, NULL_NODE);
        push_req(CMD_ALLOC,  NO_PARENT, NO_PARENT);
        push_req(CMD_UPDATE, 8'd2, ROOT_NODE);
        push_req(CMD_UPDATE, 8'd3, 8'd2);
        push_req(CMD_UPDATE, 8'd4, 8'd3);
        push_req(CMD_LOOKUP, 8'd4, NULL_NODE);
        push_req(CMD_LOOKUP, ROOT_NODE, NULL_NODE);
        push_req(CMD_LOOKUP, NULL_NODE, NO_PARENT);
        push_req(CMD_LOOKUP, NO_PARENT, NO_PARENT);
        // refused updates: zero parent, address out of range, loop, self parent
        push_req(CMD_UPDATE, 8'd5, NULL_NODE);
        push_req(CMD_UPDATE, 8'd200, 8'd3);
        push_req(CMD_UPDATE, 8'd6, 8'd40);
        push_req(CMD_UPDATE, 8'd2, 8'd4);
        push_req(CMD_UPDATE, 8'd31, 8'd31);
        push_req(CMD_QUERY,  8'd2, 8'd4);
        push_req(CMD_QUERY,  8'd4, 8'd2);
        push_req(CMD_QUERY,  NO_PARENT, NULL_NODE);
        push_req(CMD_QUERY,  NULL_NODE, NO_PARENT);
        // removal prunes the orphaned subtree
        push_req(CMD_UPDATE, 8'd3, NO_PARENT);
        push_req(CMD_UPDATE, NO_PARENT, NO_PARENT);
        push_req(CMD_UPDATE, ROOT_NODE, 8'd7);
        push_req(CMD_LOOKUP, ROOT_NODE, NULL_NODE);
        push_req(CMD_ALLOC,  NULL_NODE, NULL_NODE);
      end
      for (i = 0; i < RAND_WORDS; i++) pending_reqs.push_back(random_request());
    end
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    bad_words += results_due.size();
    if (bad_words == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
